/* hdl/spt_pkg.sv */
// spt_pkg: shared types and constants for the sedentary presence tracker.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package spt_pkg;

	localparam int CODE_W   = 8;
	localparam int TIME_W   = 32;
	localparam int PHASE_W  = 2;
	localparam int LEVEL_W  = 2;
	localparam int SEC_W    = 23;
	localparam int CFG_IDX_W = 2;

	localparam logic [TIME_W-1:0] GAP_LIMIT_MS = 32'd2000;
	localparam logic [TIME_W-1:0] GAP_SUBST_MS = 32'd100;
	localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};

	localparam logic [CODE_W-1:0] CODE_NONE   = 8'h00;
	localparam logic [CODE_W-1:0] CODE_MOVING = 8'h01;
	localparam logic [CODE_W-1:0] CODE_STILL  = 8'h02;
	localparam logic [CODE_W-1:0] CODE_BOTH   = 8'h03;

	localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
	localparam logic [PHASE_W-1:0] PH_SITTING = 2'd1;
	localparam logic [PHASE_W-1:0] PH_LIGHT   = 2'd2;
	localparam logic [PHASE_W-1:0] PH_HEAVY   = 2'd3;

	localparam logic [LEVEL_W-1:0] LVL_NONE  = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_LIGHT = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_HEAVY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LIGHT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAVY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOTION = 2'd2;

	localparam logic [TIME_W-1:0] LIGHT_RESET  = 32'd2700000;
	localparam logic [TIME_W-1:0] HEAVY_RESET  = 32'd4500000;
	localparam logic [TIME_W-1:0] MOTION_RESET = 32'd30000;

	// x / 1000 == (x * SEC_RECIP) >> SEC_SHIFT for all 32-bit x
	localparam int RECIP_W   = 29;
	localparam int PROD_W    = TIME_W + RECIP_W;
	localparam int SEC_SHIFT = 38;
	localparam logic [RECIP_W-1:0] SEC_RECIP = 29'd274877907;

	typedef struct packed {
		logic [TIME_W-1:0] light_ms;
		logic [TIME_W-1:0] heavy_ms;
		logic [TIME_W-1:0] motion_ms;
	} spt_cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [LEVEL_W-1:0] alert_level;
		logic               alert_new;
		logic [TIME_W-1:0]  still_ms;
	} spt_res_t;

endpackage

/* hdl/spt_ifs.sv */
// spt_ifs: valid/ready channel interfaces for sensor input, results and config.
// Depends on spt_pkg.
`timescale 1ns / 1ps

interface spt_in_if;
	logic                       valid;
	logic                       ready;
	logic [spt_pkg::CODE_W-1:0] presence_code;
	logic [spt_pkg::TIME_W-1:0] now_ms;
	modport source (output valid, presence_code, now_ms, input ready);
	modport sink (input valid, presence_code, now_ms, output ready);
endinterface

interface spt_out_if;
	logic                        valid;
	logic                        ready;
	logic [spt_pkg::PHASE_W-1:0] phase;
	logic [spt_pkg::LEVEL_W-1:0] alert_level;
	logic                        alert_new;
	logic [spt_pkg::SEC_W-1:0]   seated_seconds;
	modport source (output valid, phase, alert_level, alert_new, seated_seconds, input ready);
	modport sink (input valid, phase, alert_level, alert_new, seated_seconds, output ready);
endinterface

interface spt_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [spt_pkg::CFG_IDX_W-1:0] index;
	logic [spt_pkg::TIME_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/spt_core.sv */
// spt_core: tracker state and the per-transaction update of phase and accumulators.
// Depends on spt_pkg.
`timescale 1ns / 1ps

module spt_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [spt_pkg::CODE_W-1:0] code,
	input  logic [spt_pkg::TIME_W-1:0] now,
	input  spt_pkg::spt_cfg_t          cfg,
	output spt_pkg::spt_res_t          res
);

	logic [spt_pkg::TIME_W-1:0]  last_q;
	logic [spt_pkg::PHASE_W-1:0] phase_q;
	logic [spt_pkg::TIME_W-1:0]  still_q;
	logic [spt_pkg::TIME_W-1:0]  motion_q;
	logic [spt_pkg::LEVEL_W-1:0] grade_q;

	logic [spt_pkg::TIME_W-1:0]  diff;
	logic [spt_pkg::TIME_W-1:0]  gap;
	logic [spt_pkg::TIME_W:0]    still_sum;
	logic [spt_pkg::TIME_W:0]    motion_sum;
	logic [spt_pkg::TIME_W-1:0]  still_sat;
	logic [spt_pkg::TIME_W-1:0]  motion_sat;
	logic [spt_pkg::PHASE_W-1:0] phase_d;
	logic [spt_pkg::TIME_W-1:0]  still_d;
	logic [spt_pkg::TIME_W-1:0]  motion_d;
	logic [spt_pkg::LEVEL_W-1:0] grade_d;
	logic                        fresh;

	assign diff       = now - last_q;
	assign gap        = (diff > spt_pkg::GAP_LIMIT_MS) ? spt_pkg::GAP_SUBST_MS : diff;
	assign still_sum  = {1'b0, still_q} + {1'b0, gap};
	assign motion_sum = {1'b0, motion_q} + {1'b0, gap};
	assign still_sat  = still_sum[spt_pkg::TIME_W] ? spt_pkg::TIME_MAX
		: still_sum[spt_pkg::TIME_W-1:0];
	assign motion_sat = motion_sum[spt_pkg::TIME_W] ? spt_pkg::TIME_MAX
		: motion_sum[spt_pkg::TIME_W-1:0];

	always_comb begin
		phase_d  = phase_q;
		still_d  = still_q;
		motion_d = motion_q;
		grade_d  = grade_q;
		fresh    = 1'b0;
		case (code)
			spt_pkg::CODE_NONE: begin
				still_d  = '0;
				motion_d = '0;
				phase_d  = spt_pkg::PH_IDLE;
			end
			spt_pkg::CODE_STILL: begin
				still_d  = still_sat;
				motion_d = '0;
				if (phase_q != spt_pkg::PH_HEAVY && still_sat >= cfg.heavy_ms) begin
					phase_d = spt_pkg::PH_HEAVY;
					grade_d = spt_pkg::LVL_HEAVY;
					fresh   = 1'b1;
				end else if ((phase_q == spt_pkg::PH_IDLE || phase_q == spt_pkg::PH_SITTING)
						&& still_sat >= cfg.light_ms) begin
					phase_d = spt_pkg::PH_LIGHT;
					grade_d = spt_pkg::LVL_LIGHT;
					fresh   = 1'b1;
				end else if (phase_q == spt_pkg::PH_IDLE) begin
					phase_d = spt_pkg::PH_SITTING;
				end
			end
			spt_pkg::CODE_MOVING, spt_pkg::CODE_BOTH: begin
				if (motion_sat >= cfg.motion_ms) begin
					still_d  = '0;
					motion_d = '0;
					phase_d  = spt_pkg::PH_IDLE;
				end else begin
					motion_d = motion_sat;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			phase_q  <= spt_pkg::PH_IDLE;
			still_q  <= '0;
			motion_q <= '0;
			grade_q  <= spt_pkg::LVL_NONE;
		end else if (step) begin
			last_q   <= now;
			phase_q  <= phase_d;
			still_q  <= still_d;
			motion_q <= motion_d;
			grade_q  <= grade_d;
		end
	end

	assign res.phase       = phase_d;
	assign res.alert_level = grade_d;
	assign res.alert_new   = fresh;
	assign res.still_ms    = still_d;

endmodule

/* hdl/sedentary_presence_tracker.sv */
// sedentary_presence_tracker: top level with input register, state update,
// seconds conversion and output register. Depends on spt_pkg, spt_ifs, spt_core.
//
// Usage:
//   sensor : one transaction per radar report (presence_code, now_ms).
//   result : one transaction per report, in order (phase, alert_level,
//            alert_new, seated_seconds).
//   cfg    : register writes, index 0 light, 1 heavy, 2 motion reset time;
//            index 3 is ignored. Always ready; write only while idle.
// Pipeline: three register stages in all (input register, state update
//   register, divide-by-1000 multiply into the output register).
// Throughput: one report per cycle while the output is not stalled, set by
//   the state update loop in spt_core.
// Reset: arst_n clears pipeline valids, tracker state (idle, empty
//   accumulators, no warning) and restores the default thresholds.
// Stall: while result.ready is low the output holds; the three stages fill
//   and sensor.ready drops once all are occupied. No transaction is lost.
`timescale 1ns / 1ps

module sedentary_presence_tracker (
	input logic          clk,
	input logic          arst_n,
	spt_in_if.sink       sensor,
	spt_out_if.source    result,
	spt_cfg_if.sink      cfg
);

	spt_pkg::spt_cfg_t cfg_q;

	logic                       v_s1;
	logic [spt_pkg::CODE_W-1:0] code_s1;
	logic [spt_pkg::TIME_W-1:0] now_s1;

	logic              v_s2;
	spt_pkg::spt_res_t res_s2;
	spt_pkg::spt_res_t res_d;

	logic                        v_s3;
	logic [spt_pkg::PHASE_W-1:0] phase_s3;
	logic [spt_pkg::LEVEL_W-1:0] level_s3;
	logic                        new_s3;
	logic [spt_pkg::SEC_W-1:0]   sec_s3;

	logic                        rdy1;
	logic                        rdy2;
	logic                        rdy3;
	logic                        step;
	logic [spt_pkg::PROD_W-1:0]  prod;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_ms  <= spt_pkg::LIGHT_RESET;
			cfg_q.heavy_ms  <= spt_pkg::HEAVY_RESET;
			cfg_q.motion_ms <= spt_pkg::MOTION_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				spt_pkg::REG_LIGHT:  cfg_q.light_ms  <= cfg.data;
				spt_pkg::REG_HEAVY:  cfg_q.heavy_ms  <= cfg.data;
				spt_pkg::REG_MOTION: cfg_q.motion_ms <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign rdy3         = !v_s3 || result.ready;
	assign rdy2         = !v_s2 || rdy3;
	assign rdy1         = !v_s1 || rdy2;
	assign sensor.ready = rdy1;
	assign step         = v_s1 && rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= sensor.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && sensor.valid) begin
			code_s1 <= sensor.presence_code;
			now_s1  <= sensor.now_ms;
		end
		if (step) res_s2 <= res_d;
		if (rdy3 && v_s2) begin
			phase_s3 <= res_s2.phase;
			level_s3 <= res_s2.alert_level;
			new_s3   <= res_s2.alert_new;
			sec_s3   <= prod[spt_pkg::SEC_SHIFT +: spt_pkg::SEC_W];
		end
	end

	spt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.code   (code_s1),
		.now    (now_s1),
		.cfg    (cfg_q),
		.res    (res_d)
	);

	assign prod = {{spt_pkg::RECIP_W{1'b0}}, res_s2.still_ms}
		* {{spt_pkg::TIME_W{1'b0}}, spt_pkg::SEC_RECIP};

	assign result.valid          = v_s3;
	assign result.phase          = phase_s3;
	assign result.alert_level    = level_s3;
	assign result.alert_new      = new_s3;
	assign result.seated_seconds = sec_s3;

endmodule

/* hdl/spt_checker.sv */
// spt_checker: port-level assertions for the tracker, bound to the top level.
// Depends on spt_pkg and sedentary_presence_tracker.
`timescale 1ns / 1ps

module spt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [spt_pkg::PHASE_W-1:0] phase,
	input logic [spt_pkg::LEVEL_W-1:0] alert_level,
	input logic                        alert_new,
	input logic [spt_pkg::SEC_W-1:0]   seated_seconds
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(alert_level)
			&& $stable(alert_new) && $stable(seated_seconds))
		else $error("result changed while stalled");

	a_new_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alert_new |-> alert_level != spt_pkg::LVL_NONE)
		else $error("new warning without a level");

	a_warn_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (phase == spt_pkg::PH_LIGHT || phase == spt_pkg::PH_HEAVY)
			|-> (phase == spt_pkg::PH_LIGHT && alert_level == spt_pkg::LVL_LIGHT)
			|| (phase == spt_pkg::PH_HEAVY && alert_level == spt_pkg::LVL_HEAVY))
		else $error("warning phase and level disagree");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == spt_pkg::PH_IDLE |-> seated_seconds == '0)
		else $error("idle with stillness accumulated");

endmodule

bind sedentary_presence_tracker spt_checker u_spt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.phase          (result.phase),
	.alert_level    (result.alert_level),
	.alert_new      (result.alert_new),
	.seated_seconds (result.seated_seconds)
);

/* dv/spt_tb_pkg.sv */
// spt_tb_pkg: scoreboard for the sedentary presence tracker testbench, with its own
// copy of tracker state and thresholds. Depends on spt_pkg.
`timescale 1ns / 1ps

package spt_tb_pkg;
	import spt_pkg::*;

	localparam int MS_PER_S = 1000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct {
		logic [PHASE_W-1:0] phase;
		logic [LEVEL_W-1:0] level;
		logic               fresh;
		logic [SEC_W-1:0]   secs;
	} posture_t;

	class presence_scoreboard;
		spt_cfg_t          thresholds;
		logic [TIME_W-1:0] last_ms;
		logic [TIME_W-1:0] still_ms;
		logic [TIME_W-1:0] motion_ms;
		logic [PHASE_W-1:0] phase;
		logic [LEVEL_W-1:0] level;
		posture_t          awaited[$];
		int                errors;

		function new();
			thresholds.light_ms  = LIGHT_RESET;
			thresholds.heavy_ms  = HEAVY_RESET;
			thresholds.motion_ms = MOTION_RESET;
			last_ms   = '0;
			still_ms  = '0;
			motion_ms = '0;
			phase     = PH_IDLE;
			level     = LVL_NONE;
			errors    = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
			case (idx)
				REG_LIGHT: begin
					thresholds.light_ms = data;
				end
				REG_HEAVY: begin
					thresholds.heavy_ms = data;
				end
				REG_MOTION: begin
					thresholds.motion_ms = data;
				end
				default: begin
				end
			endcase
		endfunction

		function logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
			logic [TIME_W:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
		endfunction

		// one sensor transaction accepted: advance tracker state, queue the result
		function void note_report(logic [CODE_W-1:0] code, logic [TIME_W-1:0] stamp);
			logic [TIME_W-1:0] gap;
			posture_t want;
			gap = stamp - last_ms;
			last_ms = stamp;
			if (gap > GAP_LIMIT_MS) begin
				gap = GAP_SUBST_MS;
			end
			want.fresh = 1'b0;
			if (code == CODE_NONE) begin
				still_ms  = '0;
				motion_ms = '0;
				phase     = PH_IDLE;
			end else if (code == CODE_STILL) begin
				still_ms  = sat_sum(still_ms, gap);
				motion_ms = '0;
				if (phase != PH_HEAVY && still_ms >= thresholds.heavy_ms) begin
					phase = PH_HEAVY;
					level = LVL_HEAVY;
					want.fresh = 1'b1;
				end else if ((phase == PH_IDLE || phase == PH_SITTING) &&
						still_ms >= thresholds.light_ms) begin
					phase = PH_LIGHT;
					level = LVL_LIGHT;
					want.fresh = 1'b1;
				end else if (phase == PH_IDLE) begin
					phase = PH_SITTING;
				end
			end else if (code == CODE_MOVING || code == CODE_BOTH) begin
				motion_ms = sat_sum(motion_ms, gap);
				if (motion_ms >= thresholds.motion_ms) begin
					still_ms  = '0;
					motion_ms = '0;
					phase     = PH_IDLE;
				end
			end
			want.phase = phase;
			want.level = level;
			want.secs  = SEC_W'(still_ms / MS_PER_S);
			awaited.push_back(want);
		endfunction

		function void check_result(logic [PHASE_W-1:0] got_phase, logic [LEVEL_W-1:0] got_level,
				logic got_fresh, logic [SEC_W-1:0] got_secs);
			posture_t want;
			if (awaited.size() == 0) begin
				$error("result transaction with no report outstanding");
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got_phase !== want.phase) begin
				$error("phase: expected %0d, got %0d", want.phase, got_phase);
				errors++;
			end
			if (got_level !== want.level) begin
				$error("alert_level: expected %0d, got %0d", want.level, got_level);
				errors++;
			end
			if (got_fresh !== want.fresh) begin
				$error("alert_new: expected %0d, got %0d", want.fresh, got_fresh);
				errors++;
			end
			if (got_secs !== want.secs) begin
				$error("seated_seconds: expected %0d, got %0d", want.secs, got_secs);
				errors++;
			end
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction
	endclass

endpackage

/* dv/sedentary_presence_tracker_tb.sv */
// sedentary_presence_tracker_tb: directed and random radar reports under several
// threshold settings, results checked in order against the scoreboard.
// Depends on spt_pkg, spt_ifs, spt_tb_pkg and the tracker RTL.
`timescale 1ns / 1ps

module sedentary_presence_tracker_tb;
	import spt_pkg::*;
	import spt_tb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	bit   steady;
	int   cycles;
	logic [TIME_W-1:0] tick_ms;

	spt_in_if  sensor_ch();
	spt_out_if result_ch();
	spt_cfg_if cfg_ch();

	presence_scoreboard posture_sb = new();

	sedentary_presence_tracker DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sensor (sensor_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			posture_sb.check_result(result_ch.phase, result_ch.alert_level,
				result_ch.alert_new, result_ch.seated_seconds);
		end
	end

	always @(negedge clk) begin
		result_ch.ready = steady || ($urandom_range(99) >= 15);
	end

	task automatic send_report(logic [CODE_W-1:0] code, logic [TIME_W-1:0] stamp);
		@(negedge clk);
		if (!steady && $urandom_range(99) < 15) begin
			sensor_ch.valid = 1'b0;
			@(negedge clk);
		end
		sensor_ch.valid         = 1'b1;
		sensor_ch.presence_code = code;
		sensor_ch.now_ms        = stamp;
		do @(posedge clk); while (sensor_ch.ready !== 1'b1);
		posture_sb.note_report(code, stamp);
	endtask

	// stop sending and wait for every outstanding result
	task automatic settle();
		@(negedge clk);
		sensor_ch.valid = 1'b0;
		while (posture_sb.outstanding() > 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		posture_sb.write_register(idx, data);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic set_thresholds(logic [TIME_W-1:0] light, logic [TIME_W-1:0] heavy,
			logic [TIME_W-1:0] motion);
		write_register(REG_LIGHT, light);
		write_register(REG_HEAVY, heavy);
		write_register(REG_MOTION, motion);
	endtask

	function automatic logic [TIME_W-1:0] advance_tick();
		int r;
		r = $urandom_range(99);
		if (r < 8) begin
			tick_ms = $urandom();
		end else if (r < 15) begin
			tick_ms += $urandom_range(2001, 70000);
		end else if (r < 30) begin
			tick_ms += $urandom_range(0, 50);
		end else begin
			tick_ms += $urandom_range(0, 2000);
		end
		return tick_ms;
	endfunction

	// runs of still or motion reports with random timing, plus empty scenes and noise
	task automatic random_reports(int count, int hold_at);
		int done;
		int mode;
		int run;
		logic [CODE_W-1:0] code;
		done = 0;
		while (done < count) begin
			mode = $urandom_range(99);
			run  = (mode < 65) ? $urandom_range(1, 25) : $urandom_range(1, 3);
			for (int i = 0; i < run; i++) begin
				if (mode < 45) begin
					code = CODE_STILL;
				end else if (mode < 65) begin
					code = $urandom_range(1) ? CODE_BOTH : CODE_MOVING;
				end else if (mode < 72) begin
					code = CODE_NONE;
				end else if (mode < 80) begin
					code = CODE_W'($urandom_range(4, 255));
				end else begin
					code = CODE_W'($urandom_range(0, 255));
				end
				send_report(code, advance_tick());
				if (code <= CODE_BOTH) begin
					done++;
					if (done == hold_at) begin
						settle();
					end
				end
			end
		end
	endtask

	initial begin
		logic [CODE_W-1:0] dir_code[22] = '{
			CODE_STILL, CODE_STILL, CODE_STILL, CODE_STILL, CODE_STILL, CODE_STILL,
			CODE_MOVING, CODE_STILL, CODE_BOTH, CODE_MOVING, 8'hFF, CODE_STILL,
			8'h04, CODE_NONE, 8'h80, CODE_STILL, CODE_BOTH, CODE_MOVING,
			CODE_STILL, 8'hAA, 8'h55, CODE_NONE};
		logic [TIME_W-1:0] dir_stamp[22] = '{
			32'd0, 32'd1500, 32'd3500, 32'd5501, 32'd7000, 32'd8000,
			32'd9000, 32'd9100, 32'd10500, 32'd12000, 32'hFFFF_FFF0, 32'h0000_0010,
			32'h0000_0020, 32'h0000_0030, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA};

		steady                  = 1'b0;
		tick_ms                 = '0;
		arst_n                  = 1'b0;
		sensor_ch.valid         = 1'b0;
		sensor_ch.presence_code = '0;
		sensor_ch.now_ms        = '0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.index            = '0;
		cfg_ch.data             = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default thresholds: no warning is reachable, but motion clearing is
		random_reports(100, -1);
		settle();

		set_thresholds(32'd3000, 32'd5000, 32'd2500);
		for (int i = 0; i < 22; i++) begin
			send_report(dir_code[i], dir_stamp[i]);
		end
		settle();

		set_thresholds('0, '0, '0);
		random_reports(80, -1);
		settle();

		set_thresholds(TIME_MAX, TIME_MAX, TIME_MAX);
		write_register(REG_SPARE, $urandom());
		tick_ms = TIME_MAX - 32'd5000;
		random_reports(80, -1);
		settle();

		for (int k = 0; k < 6; k++) begin
			set_thresholds($urandom_range(0, 20000), $urandom_range(0, 40000),
				$urandom_range(0, 8000));
			if (k == 4) begin
				write_register(REG_SPARE, '0);
			end
			steady = (k == 2);
			random_reports(130, (k == 3) ? 60 : -1);
			steady = 1'b0;
			settle();
		end

		if (posture_sb.errors == 0 && posture_sb.outstanding() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
